// ===== src/sqv_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqv_pkg: shared types and constants for the sprite quad vertex generator
// Request and vertex payloads, anchor codes, CORDIC tables and pipeline
// depths used across the front, vertex and divider stages.
// ---------------------------------------------------------------------------
package sqv_pkg;

    // Request item as it arrives on the input channel
    typedef struct packed {
        logic [3:0]         anchor;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic [15:0]        dest_w;
        logic [15:0]        dest_h;
        logic [15:0]        src_x;
        logic [15:0]        src_y;
        logic [15:0]        src_w;
        logic [15:0]        src_h;
        logic [15:0]        turn_angle;
        logic [31:0]        tint;
    } sprite_req_t;

    // Vertex item as it leaves on the output channel
    typedef struct packed {
        logic [1:0]         corner;
        logic signed [15:0] ndc_x;
        logic signed [15:0] ndc_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        vertex_tint;
        logic               last;
    } vertex_t;

    // Anchor codes
    typedef enum logic [3:0] {
        ANCHOR_CENTER       = 4'd0,
        ANCHOR_LEFT_TOP     = 4'd1,
        ANCHOR_RIGHT_TOP    = 4'd2,
        ANCHOR_LEFT_BOTTOM  = 4'd3,
        ANCHOR_RIGHT_BOTTOM = 4'd4,
        ANCHOR_TOP          = 4'd5,
        ANCHOR_BOTTOM       = 4'd6,
        ANCHOR_LEFT         = 4'd7,
        ANCHOR_RIGHT        = 4'd8
    } anchor_e;

    // Configuration register indexes
    localparam logic [2:0] REG_VIEWPORT_WIDTH  = 3'd0;
    localparam logic [2:0] REG_VIEWPORT_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TEXTURE_WIDTH   = 3'd2;
    localparam logic [2:0] REG_TEXTURE_HEIGHT  = 3'd3;

    localparam logic [12:0] RST_VIEWPORT_WIDTH  = 13'd1280;
    localparam logic [12:0] RST_VIEWPORT_HEIGHT = 13'd720;
    localparam logic [12:0] RST_TEXTURE_WIDTH   = 13'd8;
    localparam logic [12:0] RST_TEXTURE_HEIGHT  = 13'd8;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    // Effective divisors, zero already mapped to one
    typedef struct packed {
        logic [12:0] vp_w;
        logic [12:0] vp_h;
        logic [12:0] tx_w;
        logic [12:0] tx_h;
    } cfg_t;

    // CORDIC constants: one and gain in Q2.30, arctangents in 2^-32 turn units
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [32:0] Q30_ONE     = 33'sd1073741824;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [32:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
    };

    // Divider geometry
    localparam int DIV_NUM_W = 30;
    localparam int DIV_DEN_W = 14;
    localparam int DIV_Q_W   = 17;

    // Item leaving the front pipeline: geometry plus cos and sin
    typedef struct packed {
        logic signed [17:0] cx;
        logic signed [17:0] cy;
        logic [15:0]        dw;
        logic [15:0]        dh;
        logic [16:0]        u0_pos;
        logic [16:0]        u1_pos;
        logic [16:0]        v0_pos;
        logic [16:0]        v1_pos;
        logic [31:0]        tint;
        logic signed [32:0] cos_q;
        logic signed [32:0] sin_q;
    } quad_t;

endpackage

// ===== src/sprite_quad_vertex_gen.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_quad_vertex_gen: rotated sprite quad setup
// Turns one sprite draw request into four strip-ordered vertices with
// device and texture coordinates.
// ---------------------------------------------------------------------------
//  channel  handshake             payload                 role
//  req      req_valid/req_ready   req (sprite_req_t)      draw request in
//  vtx      vtx_valid/vtx_ready   vtx (vertex_t)          vertex out
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data     register write
//
//  Each request gives four vertices through the single vertex output; a held
//  quad frees the corner expander only as its fourth corner goes out.
//  Before its first vertex appears, a request passes 17 capture and
//  CORDIC stages, the corner expander, 3 rotate stages, 17 divider stages,
//  and the output register.
//  Reset clears all valid bits and loads the register reset values.
//  A stalled output freezes the vertex pipe; the front pipe keeps taking
//  requests until its last stage is full.
// ---------------------------------------------------------------------------
module sprite_quad_vertex_gen (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  sqv_pkg::sprite_req_t req,
    output logic                 vtx_valid,
    input  logic                 vtx_ready,
    output sqv_pkg::vertex_t     vtx,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [12:0]          cfg_data
);
    import sqv_pkg::*;

    logic [12:0] vp_w_reg, vp_h_reg, tx_w_reg, tx_h_reg;
    cfg_t        cfg;
    logic        quad_valid;
    logic        quad_ready;
    quad_t       quad;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_w_reg <= RST_VIEWPORT_WIDTH;
            vp_h_reg <= RST_VIEWPORT_HEIGHT;
            tx_w_reg <= RST_TEXTURE_WIDTH;
            tx_h_reg <= RST_TEXTURE_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_VIEWPORT_WIDTH:  vp_w_reg <= cfg_data;
                REG_VIEWPORT_HEIGHT: vp_h_reg <= cfg_data;
                REG_TEXTURE_WIDTH:   tx_w_reg <= cfg_data;
                REG_TEXTURE_HEIGHT:  tx_h_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Zero divisor acts as one
    assign cfg.vp_w = (vp_w_reg == 13'd0) ? 13'd1 : vp_w_reg;
    assign cfg.vp_h = (vp_h_reg == 13'd0) ? 13'd1 : vp_h_reg;
    assign cfg.tx_w = (tx_w_reg == 13'd0) ? 13'd1 : tx_w_reg;
    assign cfg.tx_h = (tx_h_reg == 13'd0) ? 13'd1 : tx_h_reg;

    sqv_cordic u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad       (quad)
    );

    sqv_vertex u_vertex (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad       (quad),
        .vtx_valid  (vtx_valid),
        .vtx_ready  (vtx_ready),
        .vtx        (vtx)
    );

endmodule

// ===== src/sqv_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqv_div: pipelined unsigned restoring divider
// One quotient bit per stage, 17 stages, with an overflow flag for
// quotients that do not fit in 17 bits.
// ---------------------------------------------------------------------------
module sqv_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [sqv_pkg::DIV_NUM_W-1:0] num,
    input  logic [sqv_pkg::DIV_DEN_W-1:0] den,
    output logic [sqv_pkg::DIV_Q_W-1:0]   quot,
    output logic                          ovf
);
    import sqv_pkg::*;

    localparam int CMP_W = DIV_NUM_W + 1;

    logic [DIV_NUM_W-1:0] r_reg   [0:DIV_Q_W-1];
    logic [DIV_Q_W-1:0]   q_reg   [0:DIV_Q_W-1];
    logic [DIV_DEN_W-1:0] d_reg   [0:DIV_Q_W-1];
    logic [DIV_Q_W-1:0]   ovf_reg;
    logic [DIV_NUM_W-1:0] r_next  [0:DIV_Q_W-1];
    logic [DIV_Q_W-1:0]   q_next  [0:DIV_Q_W-1];
    logic [DIV_DEN_W-1:0] d_next  [0:DIV_Q_W-1];
    logic [DIV_Q_W-1:0]   ovf_next;

    // Resolve one quotient bit per stage, MSB first
    always_comb
    begin
        logic [CMP_W-1:0]     trial;
        logic [DIV_NUM_W-1:0] r_in;
        logic [DIV_Q_W-1:0]   q_in;
        logic [DIV_DEN_W-1:0] d_in;
        for (int j = 0; j < DIV_Q_W; j++)
        begin
            if (j == 0)
            begin
                r_in        = num;
                q_in        = '0;
                d_in        = den;
                ovf_next[0] = {1'b0, num} >= (CMP_W'(den) << DIV_Q_W);
            end
            else
            begin
                r_in        = r_reg[j-1];
                q_in        = q_reg[j-1];
                d_in        = d_reg[j-1];
                ovf_next[j] = ovf_reg[j-1];
            end
            trial     = CMP_W'(d_in) << (DIV_Q_W - 1 - j);
            d_next[j] = d_in;
            q_next[j] = q_in;
            r_next[j] = r_in;
            if ({1'b0, r_in} >= trial)
            begin
                r_next[j]                = DIV_NUM_W'({1'b0, r_in} - trial);
                q_next[j][DIV_Q_W-1-j]   = 1'b1;
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < DIV_Q_W; j++)
            begin
                r_reg[j] <= r_next[j];
                q_reg[j] <= q_next[j];
                d_reg[j] <= d_next[j];
            end
            ovf_reg <= ovf_next;
        end
    end

    assign quot = q_reg[DIV_Q_W-1];
    assign ovf  = ovf_reg[DIV_Q_W-1];

endmodule

// ===== src/sqv_cordic.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqv_cordic: request capture and CORDIC sine/cosine pipeline
// Places the rectangle centre from the anchor and runs one CORDIC
// rotation per stage; quarter-turn angles take exact values.
// ---------------------------------------------------------------------------
module sqv_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  sqv_pkg::sprite_req_t req,
    output logic                 quad_valid,
    input  logic                 quad_ready,
    output sqv_pkg::quad_t       quad
);
    import sqv_pkg::*;

    typedef struct packed {
        logic signed [17:0] cx;
        logic signed [17:0] cy;
        logic [15:0]        dw;
        logic [15:0]        dh;
        logic [16:0]        u0_pos;
        logic [16:0]        u1_pos;
        logic [16:0]        v0_pos;
        logic [16:0]        v1_pos;
        logic [31:0]        tint;
        logic [1:0]         quadrant;
        logic               exact;
        logic               flip;
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } front_t;

    front_t                st_reg  [0:CORDIC_STEPS];
    front_t                st_next [0:CORDIC_STEPS];
    front_t                cap_next;
    logic [CORDIC_STEPS:0] vld_reg;
    logic                  en;
    front_t                tail;

    assign en        = !vld_reg[CORDIC_STEPS] || quad_ready;
    assign req_ready = en;

    // Capture: centre in 1/2 pixel, source edges, CORDIC start vector
    always_comb
    begin
        logic signed [17:0] two_x;
        logic signed [17:0] two_y;
        logic signed [17:0] w_s;
        logic signed [17:0] h_s;
        logic [31:0]        ang_w;
        two_x = {req.dest_x[15], req.dest_x, 1'b0};
        two_y = {req.dest_y[15], req.dest_y, 1'b0};
        w_s   = $signed({2'b00, req.dest_w});
        h_s   = $signed({2'b00, req.dest_h});
        case (req.anchor)
            ANCHOR_LEFT_TOP, ANCHOR_LEFT_BOTTOM, ANCHOR_LEFT:    cap_next.cx = two_x + w_s;
            ANCHOR_RIGHT_TOP, ANCHOR_RIGHT_BOTTOM, ANCHOR_RIGHT: cap_next.cx = two_x - w_s;
            default:                                             cap_next.cx = two_x;
        endcase
        case (req.anchor)
            ANCHOR_LEFT_TOP, ANCHOR_RIGHT_TOP, ANCHOR_TOP:       cap_next.cy = two_y + h_s;
            ANCHOR_LEFT_BOTTOM, ANCHOR_RIGHT_BOTTOM, ANCHOR_BOTTOM:
                                                                 cap_next.cy = two_y - h_s;
            default:                                             cap_next.cy = two_y;
        endcase
        cap_next.dw       = req.dest_w;
        cap_next.dh       = req.dest_h;
        cap_next.u0_pos   = {1'b0, req.src_x};
        cap_next.u1_pos   = {1'b0, req.src_x} + {1'b0, req.src_w};
        cap_next.v0_pos   = {1'b0, req.src_y};
        cap_next.v1_pos   = {1'b0, req.src_y} + {1'b0, req.src_h};
        cap_next.tint     = req.tint;
        cap_next.quadrant = req.turn_angle[15:14];
        cap_next.exact    = (req.turn_angle[13:0] == 14'd0);
        cap_next.flip     = (req.turn_angle[15:14] == 2'd1) ||
                            (req.turn_angle[15:14] == 2'd2);
        ang_w = {req.turn_angle, 16'h0000};
        if (cap_next.flip)
        begin
            ang_w[31] = ~ang_w[31];
        end
        cap_next.x = CORDIC_GAIN;
        cap_next.y = '0;
        cap_next.z = $signed({ang_w[31], ang_w});
    end

    // One rotation step per stage
    always_comb
    begin
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        st_next[0] = cap_next;
        for (int j = 1; j <= CORDIC_STEPS; j++)
        begin
            st_next[j] = st_reg[j-1];
            xs = $signed(st_reg[j-1].x) >>> (j - 1);
            ys = $signed(st_reg[j-1].y) >>> (j - 1);
            if (!st_reg[j-1].z[32])
            begin
                st_next[j].x = st_reg[j-1].x - ys;
                st_next[j].y = st_reg[j-1].y + xs;
                st_next[j].z = st_reg[j-1].z - ATAN_TAB[j-1];
            end
            else
            begin
                st_next[j].x = st_reg[j-1].x + ys;
                st_next[j].y = st_reg[j-1].y - xs;
                st_next[j].z = st_reg[j-1].z + ATAN_TAB[j-1];
            end
        end
    end

    // Hold valid bits under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[CORDIC_STEPS-1:0], req_valid};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j <= CORDIC_STEPS; j++)
            begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    // Pick exact or rotated cos and sin, undo the half-turn fold
    assign tail = st_reg[CORDIC_STEPS];

    always_comb
    begin
        quad.cx     = tail.cx;
        quad.cy     = tail.cy;
        quad.dw     = tail.dw;
        quad.dh     = tail.dh;
        quad.u0_pos = tail.u0_pos;
        quad.u1_pos = tail.u1_pos;
        quad.v0_pos = tail.v0_pos;
        quad.v1_pos = tail.v1_pos;
        quad.tint   = tail.tint;
        if (tail.exact)
        begin
            case (tail.quadrant)
                2'd0:
                begin
                    quad.cos_q = Q30_ONE;
                    quad.sin_q = '0;
                end
                2'd1:
                begin
                    quad.cos_q = '0;
                    quad.sin_q = Q30_ONE;
                end
                2'd2:
                begin
                    quad.cos_q = -Q30_ONE;
                    quad.sin_q = '0;
                end
                default:
                begin
                    quad.cos_q = '0;
                    quad.sin_q = -Q30_ONE;
                end
            endcase
        end
        else if (tail.flip)
        begin
            quad.cos_q = -tail.x;
            quad.sin_q = -tail.y;
        end
        else
        begin
            quad.cos_q = tail.x;
            quad.sin_q = tail.y;
        end
    end

    assign quad_valid = vld_reg[CORDIC_STEPS];

endmodule

// ===== src/sqv_vertex.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqv_vertex: corner expander and vertex arithmetic pipeline
// Splits each quad into four corners, rotates them, then divides by the
// viewport and texture sizes in four parallel dividers and saturates.
// ---------------------------------------------------------------------------
module sqv_vertex (
    input  logic             clk,
    input  logic             rst_n,
    input  sqv_pkg::cfg_t    cfg,
    input  logic             quad_valid,
    output logic             quad_ready,
    input  sqv_pkg::quad_t   quad,
    output logic             vtx_valid,
    input  logic             vtx_ready,
    output sqv_pkg::vertex_t vtx
);
    import sqv_pkg::*;

    typedef struct packed {
        logic [1:0]         k;
        logic [31:0]        tint;
        logic signed [17:0] cx;
        logic signed [17:0] cy;
        logic signed [50:0] cox;
        logic signed [50:0] soy;
        logic signed [50:0] sox;
        logic signed [50:0] coy;
        logic [16:0]        upos;
        logic [16:0]        vpos;
    } v1_t;

    typedef struct packed {
        logic [1:0]         k;
        logic [31:0]        tint;
        logic signed [51:0] px;
        logic signed [51:0] py;
        logic [16:0]        upos;
        logic [16:0]        vpos;
    } v2_t;

    typedef struct packed {
        logic [1:0]  k;
        logic [31:0] tint;
        logic        negx;
        logic        negy;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic [DIV_NUM_W-1:0] nx_num;
        logic [DIV_NUM_W-1:0] ny_num;
        logic [DIV_NUM_W-1:0] u_num;
        logic [DIV_NUM_W-1:0] v_num;
        logic [DIV_DEN_W-1:0] nx_den;
        logic [DIV_DEN_W-1:0] ny_den;
        logic [DIV_DEN_W-1:0] u_den;
        logic [DIV_DEN_W-1:0] v_den;
    } v3_t;

    quad_t              hold_reg;
    logic               hold_vld_reg;
    logic [1:0]         cnt_reg;
    logic               en;
    logic               emit;
    v1_t                v1_reg, v1_next;
    v2_t                v2_reg, v2_next;
    v3_t                v3_reg, v3_next;
    logic               v1_vld_reg, v2_vld_reg, v3_vld_reg;
    side_t              side_reg [0:DIV_Q_W-1];
    logic [DIV_Q_W-1:0] side_vld_reg;
    vertex_t            out_reg, out_next;
    logic               out_vld_reg;
    logic [DIV_Q_W-1:0] q_nx, q_ny, q_u, q_v;
    logic               o_nx, o_ny, o_u, o_v;

    // Whole vertex pipe moves unless the output item is stuck
    assign en         = !out_vld_reg || vtx_ready;
    assign emit       = hold_vld_reg && en;
    assign quad_ready = !hold_vld_reg || (emit && (cnt_reg == CORNER_LAST));

    // Hold one quad while its four corners go out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (emit)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            if (quad_ready && quad_valid)
            begin
                hold_vld_reg <= 1'b1;
                cnt_reg      <= '0;
            end
            else if (emit && (cnt_reg == CORNER_LAST))
            begin
                hold_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (quad_ready && quad_valid)
        begin
            hold_reg <= quad;
        end
    end

    // Corner offsets and rotation products
    always_comb
    begin
        logic signed [17:0] ox;
        logic signed [17:0] oy;
        logic signed [17:0] w_s;
        logic signed [17:0] h_s;
        w_s  = $signed({2'b00, hold_reg.dw});
        h_s  = $signed({2'b00, hold_reg.dh});
        ox   = cnt_reg[0] ? w_s : -w_s;
        oy   = cnt_reg[1] ? h_s : -h_s;
        v1_next.k    = cnt_reg;
        v1_next.tint = hold_reg.tint;
        v1_next.cx   = hold_reg.cx;
        v1_next.cy   = hold_reg.cy;
        v1_next.cox  = hold_reg.cos_q * ox;
        v1_next.soy  = hold_reg.sin_q * oy;
        v1_next.sox  = hold_reg.sin_q * ox;
        v1_next.coy  = hold_reg.cos_q * oy;
        v1_next.upos = cnt_reg[0] ? hold_reg.u1_pos : hold_reg.u0_pos;
        v1_next.vpos = cnt_reg[1] ? hold_reg.v1_pos : hold_reg.v0_pos;
    end

    // Rotated corner positions, 2^-31 pixel units
    always_comb
    begin
        logic signed [51:0] cxs;
        logic signed [51:0] cys;
        cxs = $signed({{4{v1_reg.cx[17]}}, v1_reg.cx, 30'b0});
        cys = $signed({{4{v1_reg.cy[17]}}, v1_reg.cy, 30'b0});
        v2_next.k    = v1_reg.k;
        v2_next.tint = v1_reg.tint;
        v2_next.px   = cxs + v1_reg.cox - v1_reg.soy;
        v2_next.py   = cys + v1_reg.sox + v1_reg.coy;
        v2_next.upos = v1_reg.upos;
        v2_next.vpos = v1_reg.vpos;
    end

    // Round offset, floor shift and fold the sign for the dividers
    always_comb
    begin
        logic signed [51:0] sum_x;
        logic signed [51:0] sum_y;
        logic [29:0]        sh_x;
        logic [29:0]        sh_y;
        sum_x = v2_reg.px + $signed({18'b0, cfg.vp_w, 21'b0});
        sum_y = v2_reg.py + $signed({18'b0, cfg.vp_h, 21'b0});
        sh_x  = sum_x[51:22];
        sh_y  = sum_y[51:22];
        v3_next.side.k    = v2_reg.k;
        v3_next.side.tint = v2_reg.tint;
        v3_next.side.negx = sh_x[29];
        v3_next.side.negy = sh_y[29];
        v3_next.nx_num    = sh_x[29] ? ~sh_x : sh_x;
        v3_next.ny_num    = sh_y[29] ? ~sh_y : sh_y;
        v3_next.u_num     = {4'b0, v2_reg.upos, 9'b0} + {17'b0, cfg.tx_w};
        v3_next.v_num     = {4'b0, v2_reg.vpos, 9'b0} + {17'b0, cfg.tx_h};
        v3_next.nx_den    = {1'b0, cfg.vp_w};
        v3_next.ny_den    = {1'b0, cfg.vp_h};
        v3_next.u_den     = {cfg.tx_w, 1'b0};
        v3_next.v_den     = {cfg.tx_h, 1'b0};
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_vld_reg   <= 1'b0;
            v2_vld_reg   <= 1'b0;
            v3_vld_reg   <= 1'b0;
            side_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            v1_vld_reg   <= emit;
            v2_vld_reg   <= v1_vld_reg;
            v3_vld_reg   <= v2_vld_reg;
            side_vld_reg <= {side_vld_reg[DIV_Q_W-2:0], v3_vld_reg};
            out_vld_reg  <= side_vld_reg[DIV_Q_W-1];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            side_reg[0] <= v3_reg.side;
            for (int j = 1; j < DIV_Q_W; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
            out_reg <= out_next;
        end
    end

    sqv_div u_div_nx (
        .clk  (clk),
        .en   (en),
        .num  (v3_reg.nx_num),
        .den  (v3_reg.nx_den),
        .quot (q_nx),
        .ovf  (o_nx)
    );

    sqv_div u_div_ny (
        .clk  (clk),
        .en   (en),
        .num  (v3_reg.ny_num),
        .den  (v3_reg.ny_den),
        .quot (q_ny),
        .ovf  (o_ny)
    );

    sqv_div u_div_u (
        .clk  (clk),
        .en   (en),
        .num  (v3_reg.u_num),
        .den  (v3_reg.u_den),
        .quot (q_u),
        .ovf  (o_u)
    );

    sqv_div u_div_v (
        .clk  (clk),
        .en   (en),
        .num  (v3_reg.v_num),
        .den  (v3_reg.v_den),
        .quot (q_v),
        .ovf  (o_v)
    );

    function automatic logic signed [15:0] sat_s16(input logic signed [18:0] v);
        if (v > 19'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -19'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Restore sign, offset to device range and saturate
    always_comb
    begin
        logic signed [18:0] qs_x;
        logic signed [18:0] qs_y;
        side_t              sd;
        sd   = side_reg[DIV_Q_W-1];
        qs_x = $signed({2'b00, q_nx});
        qs_y = $signed({2'b00, q_ny});
        if (sd.negx)
        begin
            qs_x = ~qs_x;
        end
        if (sd.negy)
        begin
            qs_y = ~qs_y;
        end
        out_next.corner      = sd.k;
        out_next.vertex_tint = sd.tint;
        out_next.last        = (sd.k == CORNER_LAST);
        if (o_nx)
        begin
            out_next.ndc_x = sd.negx ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            out_next.ndc_x = sat_s16(qs_x - 19'sd4096);
        end
        if (o_ny)
        begin
            out_next.ndc_y = sd.negy ? 16'sh7FFF : 16'sh8000;
        end
        else
        begin
            out_next.ndc_y = sat_s16(19'sd4096 - qs_y);
        end
        out_next.tex_u = (o_u || q_u[DIV_Q_W-1]) ? 16'hFFFF : q_u[15:0];
        out_next.tex_v = (o_v || q_v[DIV_Q_W-1]) ? 16'hFFFF : q_v[15:0];
    end

    assign vtx_valid = out_vld_reg;
    assign vtx       = out_reg;

    // Marker only on the fourth corner
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_reg.last == (out_reg.corner == CORNER_LAST)))
        else $error("last flag does not match corner");

    // A newly taken quad starts at the first corner
    a_take_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (quad_valid && quad_ready) |=> (hold_vld_reg && (cnt_reg == 2'd0)))
        else $error("quad taken without restart of corner count");

    // Quad stays held until its fourth corner is sent
    a_hold_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (cnt_reg != CORNER_LAST)) |=> hold_vld_reg)
        else $error("quad dropped before fourth corner");

    // Nothing enters the vertex pipe while it is frozen
    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !vtx_ready) |=> $stable(v1_vld_reg) && $stable(cnt_reg))
        else $error("vertex pipe moved while output stalled");

endmodule
